[sv/spaq_pkg.sv]
// shared types and constants for the stable priority admission queue
`timescale 1ns / 1ps
`default_nettype none

package spaq_pkg;

   localparam int PRIO_W   = 4;
   localparam int IDENT_W  = 16;
   localparam int CAP_W    = 16;
   localparam int WAIT_W   = 6;
   localparam int OP_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_ARRIVE = 2'd0;
   localparam logic [OP_W-1:0] OP_DEPART = 2'd1;
   localparam logic [OP_W-1:0] OP_DRAIN  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_NUM_PRIO = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAPACITY = 2'd1;

   localparam logic [PRIO_W-1:0] NUM_PRIO_RESET = 4'd15;

   // one queue slot
   typedef struct packed {
      logic               valid;
      logic [PRIO_W-1:0]  prio;
      logic [IDENT_W-1:0] ident;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic               insert;
      logic               pop;
      logic [PRIO_W-1:0]  prio;
      logic [IDENT_W-1:0] ident;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADMIT,
      ST_EMIT,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

[sv/spaq_cell.sv]
// one cell of the sorted waiting chain
`timescale 1ns / 1ps
`default_nettype none

module spaq_cell (
   input  wire                    clock,
   input  wire                    reset,
   input  spaq_pkg::cell_cmd_type cmd,
   input  spaq_pkg::entry_type    prev_entry,
   input  wire                    prev_ins,
   input  spaq_pkg::entry_type    next_entry,
   output spaq_pkg::entry_type    entry,
   output logic                   ins
);
   import spaq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // new entry belongs at or before this cell (stable: strictly greater moves)
   assign ins = !entry_ff.valid || (entry_ff.prio > cmd.prio);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.pop) begin
         entry_in = next_entry;
      end else if (cmd.insert && ins) begin
         if (prev_ins) begin
            entry_in = prev_entry;
         end else begin
            entry_in.valid = 1'b1;
            entry_in.prio  = cmd.prio;
            entry_in.ident = cmd.ident;
         end
      end
   end

   // valid bit is control state, payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.prio  <= entry_in.prio;
      entry_ff.ident <= entry_in.ident;
   end

   assign entry = entry_ff;

endmodule

`default_nettype wire

[sv/stable_priority_admission_queue_core.sv]
// Stable priority admission queue: sorted chain of cells with admission control.
// The req channel carries one word per operation: tuser holds the op (arrival,
// departure, drain), tdata holds priority and ident. The rsp channel returns
// one word per arrival, departure or unused op, and one word per waiting entry
// on a drain (tlast on the final one); an empty drain returns one word with
// the nobody flag. The user must write registers num_priorities and capacity
// through the csr port only while the block is idle; the block does not enforce it.
// Waiting entries sit in a row of cells kept sorted by priority, earliest first
// among equals, so the best entry is always in the head cell. An arrival with a
// valid priority and room in the chain is inserted in the cycle it is accepted;
// the admit state then pops the head if a user is admitted and loads the result
// register. A drain pops one head per cycle through the chain while the output
// register is free. The next word is accepted once the current one has
// placed its last result in the output register.
// When the receiver stalls, the result register holds its word and the block
// waits before writing another result. Reset empties the chain and the counts
// at once and restores register defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_admission_queue_core #(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // req_tdata: priority_req[3:0], ident[19:4], zero fill
   input  wire  [spaq_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: op[1:0]
   input  wire  [spaq_pkg::OP_W-1:0]            req_tuser,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: admitted_ident[15:0], inside_count[31:16], waiting_count[37:32], zero fill
   output logic [spaq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // rsp_tuser: admitted[0], nobody[1], overflow[2], bad_priority[3]
   output logic [spaq_pkg::RSP_USER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   input  wire                                  csr_wr_en,
   input  wire  [spaq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [spaq_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import spaq_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   state_type            state_ff, state_in;
   logic [PRIO_W-1:0]    num_prio_ff;
   logic [CAP_W-1:0]     capacity_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]     inside_ff, inside_in;
   logic [OP_W-1:0]      op_ff;
   logic                 nob_ff, ovf_ff, badp_ff;

   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_USER_W-1:0] rsp_user_ff;
   logic                 rsp_last_ff;

   logic [OP_W-1:0]      op_req;
   logic [PRIO_W-1:0]    prio_req;
   logic [IDENT_W-1:0]   ident_req;
   logic                 req_fire, out_free, arr_bad, arr_full, empty, admit_ok;
   logic                 do_pop, emit;
   cell_cmd_type         cmd;

   logic                 res_admitted, res_nobody, res_ovf, res_badp, res_last;
   logic [IDENT_W-1:0]   res_ident;
   logic [WAIT_W-1:0]    res_wait;

   entry_type            cell_entry [QUEUE_DEPTH];
   logic                 cell_ins   [QUEUE_DEPTH];

   // request field unpacking and status
   assign op_req    = req_tuser;
   assign prio_req  = req_tdata[PRIO_W-1:0];
   assign ident_req = req_tdata[PRIO_W +: IDENT_W];
   assign req_fire  = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign arr_bad   = prio_req > num_prio_ff;
   assign arr_full  = count_ff == CNT_FULL;
   assign empty     = count_ff == '0;
   assign admit_ok  = inside_ff < capacity_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op_req)
                  OP_ARRIVE: state_in = (arr_bad || arr_full) ? ST_EMIT : ST_ADMIT;
                  OP_DEPART: state_in = ST_ADMIT;
                  OP_DRAIN:  state_in = empty ? ST_EMIT : ST_DRAIN;
                  default:   state_in = ST_EMIT;
               endcase
            end
         end
         ST_ADMIT, ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_DRAIN: begin
            if (out_free && (count_ff == CNT_ONE)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshake, chain command, result selection
   always_comb begin
      req_tready   = 1'b0;
      do_pop       = 1'b0;
      emit         = 1'b0;
      cmd.insert   = 1'b0;
      cmd.prio     = prio_req;
      cmd.ident    = ident_req;
      res_admitted = 1'b0;
      res_nobody   = 1'b0;
      res_ovf      = 1'b0;
      res_badp     = 1'b0;
      res_last     = 1'b1;
      res_ident    = '0;
      res_wait     = WAIT_W'(count_in);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.insert = req_fire && (op_req == OP_ARRIVE) && !arr_bad && !arr_full;
         end
         ST_ADMIT: begin
            emit   = out_free;
            do_pop = out_free && !empty && ((op_ff == OP_DEPART) || admit_ok);
            res_admitted = do_pop;
            res_ident    = do_pop ? cell_entry[0].ident : '0;
         end
         ST_EMIT: begin
            emit       = out_free;
            res_nobody = nob_ff;
            res_ovf    = ovf_ff;
            res_badp   = badp_ff;
         end
         ST_DRAIN: begin
            emit         = out_free;
            do_pop       = out_free;
            res_admitted = 1'b1;
            res_ident    = cell_entry[0].ident;
            res_last     = count_ff == CNT_ONE;
            res_wait     = '0;
         end
         default: ;
      endcase
      cmd.pop = do_pop;
   end

   // counts after this step
   always_comb begin
      count_in  = count_ff;
      inside_in = inside_ff;
      if (cmd.insert) count_in = count_ff + CNT_ONE;
      if (do_pop)     count_in = count_ff - CNT_ONE;
      if (state_ff == ST_ADMIT && emit) begin
         if (op_ff == OP_ARRIVE && do_pop) begin
            inside_in = inside_ff + CAP_W'(1);
         end else if (op_ff == OP_DEPART && empty && inside_ff != '0) begin
            inside_in = inside_ff - CAP_W'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         inside_ff   <= '0;
         num_prio_ff <= NUM_PRIO_RESET;
         capacity_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         inside_ff <= inside_in;
         if (csr_wr_en && csr_index == REG_NUM_PRIO) num_prio_ff <= csr_wdata[PRIO_W-1:0];
         if (csr_wr_en && csr_index == REG_CAPACITY) capacity_ff <= csr_wdata[CAP_W-1:0];
      end
   end

   // operation latch
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff   <= op_req;
         nob_ff  <= (op_req == OP_DRAIN) && empty;
         ovf_ff  <= (op_req == OP_ARRIVE) && !arr_bad && arr_full;
         badp_ff <= (op_req == OP_ARRIVE) && arr_bad;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit) begin
         rsp_data_ff <= {(RSP_DATA_W - IDENT_W - CAP_W - WAIT_W)'(0),
                         res_wait, inside_in, res_ident};
         rsp_user_ff <= {res_badp, res_ovf, res_nobody, res_admitted};
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // sorted chain, head in cell 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type prev_e, next_e;
      logic      prev_i;
      if (i == 0) begin : g_head
         assign prev_e = '0;
         assign prev_i = 1'b0;
      end else begin : g_body
         assign prev_e = cell_entry[i-1];
         assign prev_i = cell_ins[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_e = '0;
      end else begin : g_mid
         assign next_e = cell_entry[i+1];
      end
      spaq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .prev_entry (prev_e),
         .prev_ins   (prev_i),
         .next_entry (next_e),
         .entry      (cell_entry[i]),
         .ins        (cell_ins[i])
      );
   end

endmodule

`default_nettype wire

[sv/spaq_checker.sv]
// port-level checks for the admission queue, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module spaq_checker (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_tvalid,
   input wire                                 req_tready,
   input wire [spaq_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input wire [spaq_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input wire                                 rsp_tlast,
   input wire                                 rsp_tvalid,
   input wire                                 rsp_tready
);
   import spaq_pkg::*;

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // one operation at a time
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted back to back");

   // only drain words come without last, and they always carry an admission
   a_drain_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser[0] && rsp_tdata[37:32] == '0)
      else $error("non-final word is not a drained entry");

   // flags are mutually exclusive
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones(rsp_tuser) <= 1)
      else $error("more than one status flag set");

   // empty drain reports an empty queue
   a_nobody: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tdata[37:32] == '0)
      else $error("nobody word with waiting entries");

endmodule

bind stable_priority_admission_queue_core spaq_checker u_spaq_checker (.*);

`default_nettype wire
